### sv/sfse_pkg.sv
// Package for the serial FRAM slave engine: beat types, opcodes, frame phases.
`default_nettype none

package sfse_pkg;

    // Default memory address width and output queue depth
    localparam int ADDR_BITS_DEF = 11;
    localparam int OUT_DEPTH     = 3;

    // SPI opcodes
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WRSR  = 8'h01;

    // Input beat action codes
    localparam logic ACT_XFER    = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Frame phase, one-hot
    typedef enum logic [6:0] {
        PH_OPCODE  = 7'b0000001,
        PH_ADDR_HI = 7'b0000010,
        PH_ADDR_LO = 7'b0000100,
        PH_DATA    = 7'b0001000,
        PH_SR_DATA = 7'b0010000,
        PH_SR_READ = 7'b0100000,
        PH_IGNORE  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic       action;
        logic [7:0] mosi_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] miso_byte;
        logic       latch_now;
    } t_out_beat;

endpackage

`default_nettype wire

### sv/sfse_out_fifo.sv
// Small result queue that decouples the engine from the output channel.
`default_nettype none

module sfse_out_fifo #(
    parameter int DEPTH = sfse_pkg::OUT_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire sfse_pkg::t_out_beat      i_push_data,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output sfse_pkg::t_out_beat           o_data,
    output logic [$clog2(DEPTH+1)-1:0]    o_level
);
    import sfse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    t_out_beat       r_slot [DEPTH];
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [LW-1:0]   r_level,  n_level;
    logic            w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_level != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_level = r_level;

    // Pointer and level update, pointers wrap at DEPTH
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_level  = r_level;
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_push && !w_pop) begin
            n_level = r_level + LW'(1);
        end else if (!i_push && w_pop) begin
            n_level = r_level - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_level  <= n_level;
        end
    end

    // Payload slots, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

### sv/spi_fram_slave_engine.sv
// Top level of the serial FRAM slave engine: frame decoder, memory, result queue.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | into      | i_valid / o_ready  | i_data : action, mosi_byte
//  out     | out of    | o_valid / i_ready  | o_data : miso_byte, latch_now
//
// One beat is accepted per cycle while o_ready is high. Its result is held in the
// result register, with read data taken from the memory read register, and is then
// pushed into the queue, from which it can be taken. The queue holds OUT_DEPTH
// results, so input keeps flowing while a result waits. After reset a clearing pass
// zeroes the memory, one byte per cycle, over all 2**ADDR_BITS addresses; o_ready
// stays low during it. A stalled output stops input once the queue and the result
// register together hold OUT_DEPTH results.
`default_nettype none

module spi_fram_slave_engine #(
    parameter int ADDR_BITS = sfse_pkg::ADDR_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire sfse_pkg::t_in_beat  i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output sfse_pkg::t_out_beat      o_data
);
    import sfse_pkg::*;

    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int LW        = $clog2(OUT_DEPTH + 1);

    // Frame state
    t_phase                r_phase,  n_phase;
    logic [7:0]            r_opcode, n_opcode;
    logic [ADDR_BITS-1:0]  r_addr,   n_addr;
    logic                  r_latch,  n_latch;
    logic [7:2]            r_status, n_status;

    // Clearing pass
    logic                  r_clr_busy;
    logic [ADDR_BITS-1:0]  r_clr_addr;

    // Memory
    logic [7:0]            r_mem [MEM_DEPTH];
    logic [7:0]            r_mem_q;
    logic                  w_mem_we;
    logic [ADDR_BITS-1:0]  w_mem_addr;
    logic [7:0]            w_mem_wdata;
    logic                  w_data_we;

    // Result stage
    logic                  r_s1_valid;
    logic [7:0]            r_s1_miso;
    logic                  r_s1_sel_mem;
    logic                  r_s1_latch;
    logic [7:0]            w_miso;
    logic                  w_sel_mem;
    t_out_beat             w_s1_beat;

    logic                  w_accept;
    logic [LW-1:0]         w_level;
    logic [LW:0]           w_used;
    logic [15:0]           w_addr_hi;
    logic [15:0]           w_addr_lo;

    assign w_accept = i_valid && o_ready;

    // Input ready: no clearing pass and room for everything in flight
    assign w_used  = (LW + 1)'(w_level) + (LW + 1)'(r_s1_valid);
    assign o_ready = !r_clr_busy && (w_used < (LW + 1)'(OUT_DEPTH));

    // Address byte assembly, truncated to ADDR_BITS
    assign w_addr_hi = {i_data.mosi_byte, 8'h00};
    assign w_addr_lo = 16'(r_addr) | {8'h00, i_data.mosi_byte};

    // Frame decoder: next state for one beat
    always_comb begin
        n_phase   = r_phase;
        n_opcode  = r_opcode;
        n_addr    = r_addr;
        n_latch   = r_latch;
        n_status  = r_status;
        w_miso    = 8'h00;
        w_sel_mem = 1'b0;
        w_data_we = 1'b0;
        if (w_accept) begin
            if (i_data.action == ACT_RELEASE) begin
                // frame ends; a write or status write frame drops the latch
                if (r_phase != PH_OPCODE &&
                    (r_opcode == OP_WRITE || r_opcode == OP_WRSR)) begin
                    n_latch = 1'b0;
                end
                n_phase  = PH_OPCODE;
                n_opcode = 8'h00;
            end else begin
                unique case (r_phase)
                    PH_OPCODE: begin
                        n_opcode = i_data.mosi_byte;
                        case (i_data.mosi_byte)
                            OP_WREN: begin
                                n_latch = 1'b1;
                                n_phase = PH_IGNORE;
                            end
                            OP_WRDI: begin
                                n_latch = 1'b0;
                                n_phase = PH_IGNORE;
                            end
                            OP_READ, OP_WRITE: n_phase = PH_ADDR_HI;
                            OP_RDSR:           n_phase = PH_SR_READ;
                            OP_WRSR:           n_phase = PH_SR_DATA;
                            default:           n_phase = PH_IGNORE;
                        endcase
                    end
                    PH_ADDR_HI: begin
                        n_addr  = w_addr_hi[ADDR_BITS-1:0];
                        n_phase = PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        n_addr  = w_addr_lo[ADDR_BITS-1:0];
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        if (r_opcode == OP_READ) begin
                            w_sel_mem = 1'b1;
                        end else if (r_latch) begin
                            w_data_we = 1'b1;
                        end
                        n_addr = r_addr + ADDR_BITS'(1);
                    end
                    PH_SR_DATA: begin
                        if (r_latch) begin
                            n_status = i_data.mosi_byte[7:2];
                        end
                        n_phase = PH_IGNORE;
                    end
                    PH_SR_READ: begin
                        w_miso = {r_status, r_latch, 1'b0};
                    end
                    PH_IGNORE: begin
                        n_phase = PH_IGNORE;
                    end
                    default: begin
                        n_phase = PH_IGNORE;
                    end
                endcase
            end
        end
    end

    // Memory port: clearing pass or data write
    always_comb begin
        if (r_clr_busy) begin
            w_mem_we    = 1'b1;
            w_mem_addr  = r_clr_addr;
            w_mem_wdata = 8'h00;
        end else begin
            w_mem_we    = w_data_we;
            w_mem_addr  = r_addr;
            w_mem_wdata = i_data.mosi_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_mem_q <= r_mem[r_addr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OPCODE;
            r_opcode   <= 8'h00;
            r_addr     <= '0;
            r_latch    <= 1'b0;
            r_status   <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_opcode   <= n_opcode;
            r_addr     <= n_addr;
            r_latch    <= n_latch;
            r_status   <= n_status;
            r_s1_valid <= w_accept;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // Result stage payload
    always_ff @(posedge i_clk) begin
        r_s1_miso    <= w_miso;
        r_s1_sel_mem <= w_sel_mem;
        r_s1_latch   <= n_latch;
    end

    assign w_s1_beat.miso_byte = r_s1_sel_mem ? r_mem_q : r_s1_miso;
    assign w_s1_beat.latch_now = r_s1_latch;

    // Result queue
    sfse_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_data (w_s1_beat),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .o_level     (w_level)
    );

endmodule

`default_nettype wire

### sv/sfse_checker.sv
// Port-level checker for the serial FRAM slave engine, bound to the top level.
`default_nettype none

module sfse_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_ready,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire sfse_pkg::t_out_beat o_data
);
    import sfse_pkg::*;

    logic [3:0] r_pending;
    logic       w_in_beat;
    logic       w_out_beat;

    assign w_in_beat  = i_valid && o_ready;
    assign w_out_beat = o_valid && i_ready;

    // Beats accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 4'(w_in_beat) - 4'(w_out_beat);
        end
    end

    // Reset starts the clearing pass, so no input is taken right after it
    a_reset_blocks_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("input ready right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // No result without an accepted beat
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 4'd0 |-> !o_valid)
        else $error("result with no beat outstanding");

    // In-flight beats never exceed the queue plus the result stage
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 4'(OUT_DEPTH + 1))
        else $error("too many beats outstanding");

endmodule

bind spi_fram_slave_engine sfse_checker u_sfse_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the serial FRAM slave engine, with its own bus-level chip model.
`timescale 1ns / 1ps

module testbench;
    import sfse_pkg::*;

    localparam int ABITS = ADDR_BITS_DEF;
    localparam int MEM_BYTES = 1 << ABITS;
    localparam logic [7:0] STATUS_KEEP = 8'hFC;  // status bits 1:0 are never stored
    localparam logic [7:0] OP_BOGUS = 8'hFF;     // an opcode the chip does not know
    localparam longint TIMEOUT_NS = 64'd10_000_000;
    localparam int MAX_REPORTS = 100;

    typedef logic [ABITS-1:0] t_addr;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_beat  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_beat o_data;

    // Chip model state
    t_phase     chip_phase = PH_OPCODE;
    logic [7:0] chip_opcode = '0;
    t_addr      chip_addr = '0;
    logic       chip_latch = 1'b0;
    logic [7:0] chip_status = '0;
    logic [7:0] chip_mem [0:MEM_BYTES-1];

    t_out_beat pending_results[$];
    int        err_count = 0;
    int        beats_sent = 0;
    int        burst_left = 0;

    spi_fram_slave_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advance the chip model by one beat and return the byte it shifts out
    function automatic t_out_beat fram_predict(input t_in_beat beat);
        t_out_beat res;
        res.miso_byte = 8'h00;
        if (beat.action == ACT_RELEASE) begin
            // a write or status write frame drops the latch when CS goes away
            if (chip_phase != PH_OPCODE && (chip_opcode == OP_WRITE || chip_opcode == OP_WRSR))
                chip_latch = 1'b0;
            chip_phase  = PH_OPCODE;
            chip_opcode = '0;
        end else begin
            case (chip_phase)
                PH_OPCODE: begin
                    chip_opcode = beat.mosi_byte;
                    case (beat.mosi_byte)
                        OP_WREN: begin
                            chip_latch = 1'b1;
                            chip_phase = PH_IGNORE;
                        end
                        OP_WRDI: begin
                            chip_latch = 1'b0;
                            chip_phase = PH_IGNORE;
                        end
                        OP_READ, OP_WRITE: chip_phase = PH_ADDR_HI;
                        OP_RDSR:           chip_phase = PH_SR_READ;
                        OP_WRSR:           chip_phase = PH_SR_DATA;
                        default:           chip_phase = PH_IGNORE;
                    endcase
                end
                PH_ADDR_HI: begin
                    chip_addr  = t_addr'({beat.mosi_byte, 8'h00});
                    chip_phase = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    chip_addr  = chip_addr | t_addr'(beat.mosi_byte);
                    chip_phase = PH_DATA;
                end
                PH_DATA: begin
                    if (chip_opcode == OP_READ)
                        res.miso_byte = chip_mem[chip_addr];
                    else if (chip_latch)
                        chip_mem[chip_addr] = beat.mosi_byte;
                    chip_addr = chip_addr + t_addr'(1);
                end
                PH_SR_DATA: begin
                    if (chip_latch)
                        chip_status = beat.mosi_byte & STATUS_KEEP;
                    chip_phase = PH_IGNORE;
                end
                PH_SR_READ: res.miso_byte = {chip_status[7:2], chip_latch, 1'b0};
                default:    chip_phase = PH_IGNORE;
            endcase
        end
        res.latch_now = chip_latch;
        return res;
    endfunction

    // Send one beat: bursts of random length, random gaps between them
    task automatic send_beat(input logic act, input logic [7:0] mosi);
        t_in_beat beat;
        int gap;
        beat.action    = act;
        beat.mosi_byte = mosi;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(fram_predict(beat));
        burst_left--;
        beats_sent++;
    endtask

    task automatic send_byte(input logic [7:0] mosi);
        send_beat(ACT_XFER, mosi);
    endtask

    // mosi is don't-care on a release, so it gets random content
    task automatic send_release();
        send_beat(ACT_RELEASE, 8'($urandom));
    endtask

    // Hold off the sender until every pending result has come back
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        burst_left = 0;
    endtask

    // Status register and write latch: enable, disable, status read and write
    task automatic test_status_latch();
        send_byte(OP_RDSR);
        send_byte(8'h00);
        send_release();
        // enable, then a stray byte that must be ignored
        send_byte(OP_WREN);
        send_byte(8'h55);
        send_release();
        // status write keeps bits 7:2 only, extra byte ignored, release clears latch
        send_byte(OP_WRSR);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_release();
        // repeated status read
        send_byte(OP_RDSR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_release();
        send_byte(OP_WRDI);
        send_release();
    endtask

    // Memory: truncated address, wrap, read back, unknown opcode, idle release
    task automatic test_memory_edges();
        send_byte(OP_WREN);
        send_release();
        send_byte(OP_WRITE);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_release();
        send_byte(OP_READ);
        send_byte(8'hF7);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_release();
        send_byte(OP_BOGUS);
        send_byte(8'h12);
        send_release();
        send_release();
    endtask

    // Random well-formed frames with random content, plus truncated frames and noise
    task automatic test_random_frames(input int count);
        int          start;
        int          pick;
        int          nbytes;
        int          cut;
        int          k;
        bit          drained;
        logic [15:0] addr;
        logic [7:0]  op;
        start   = beats_sent;
        drained = 1'b0;
        while (beats_sent - start < count) begin
            if (!drained && beats_sent - start >= count / 2) begin
                wait_for_drain();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // memory frame; most writes are preceded by an enable
                if (pick < 30 && $urandom_range(0, 4) != 0) begin
                    send_byte(OP_WREN);
                    send_release();
                end
                op   = (pick < 30) ? OP_WRITE : OP_READ;
                addr = 16'($urandom);
                // keep most accesses near the wrap point so reads hit written bytes
                if ($urandom_range(0, 4) < 3)
                    addr[10:0] = 11'h7F0 + 11'($urandom_range(0, 31));
                nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                     : $urandom_range(1, 6);
                // now and then the frame is cut short, even inside the address
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nbytes + 1)
                                                  : nbytes + 2;
                send_byte(op);
                for (k = 0; k < nbytes + 2 && k < cut; k++)
                    send_byte((k == 0) ? addr[15:8] : (k == 1) ? addr[7:0] : 8'($urandom));
                send_release();
            end else if (pick < 68) begin
                send_byte(OP_RDSR);
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                send_release();
            end else if (pick < 76) begin
                if ($urandom_range(0, 1) != 0) begin
                    send_byte(OP_WREN);
                    send_release();
                end
                send_byte(OP_WRSR);
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
                send_release();
            end else if (pick < 82) begin
                send_byte(($urandom_range(0, 1) != 0) ? OP_WREN : OP_WRDI);
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
                send_release();
            end else if (pick < 90) begin
                do op = 8'($urandom);
                while (op == OP_WREN || op == OP_WRDI || op == OP_READ || op == OP_WRITE ||
                       op == OP_RDSR || op == OP_WRSR);
                send_byte(op);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
                send_release();
            end else begin
                // raw noise, releases with no frame open among it
                repeat ($urandom_range(1, 4)) send_beat(1'($urandom), 8'($urandom));
            end
        end
    endtask

    // Receiver: compare each result beat, stall according to a mode that is re-picked at random
    always @(posedge i_clk) begin : rcv_side
        t_out_beat want;
        int        rcv_cycle;
        int        rcv_mode;
        logic      next_ready;
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            rcv_cycle = 0;
            rcv_mode  = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    if (err_count < MAX_REPORTS)
                        $display("%0t: result beat with none pending: miso %h latch %b",
                                 $time, o_data.miso_byte, o_data.latch_now);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_data.miso_byte !== want.miso_byte) begin
                        if (err_count < MAX_REPORTS)
                            $display("%0t: miso_byte mismatch: expected %h actual %h",
                                     $time, want.miso_byte, o_data.miso_byte);
                        err_count++;
                    end
                    if (o_data.latch_now !== want.latch_now) begin
                        if (err_count < MAX_REPORTS)
                            $display("%0t: latch_now mismatch: expected %b actual %b",
                                     $time, want.latch_now, o_data.latch_now);
                        err_count++;
                    end
                end
            end
            if (rcv_cycle % 256 == 0)
                rcv_mode = $urandom_range(0, 3);
            case (rcv_mode)
                0:       next_ready = 1'b1;
                1:       next_ready = ($urandom_range(0, 9) < 7);
                2:       next_ready = ((rcv_cycle % 16) >= 9);
                default: next_ready = ((rcv_cycle % 32) >= 20);
            endcase
            i_ready <= next_ready;
            rcv_cycle++;
        end
    end

    // Test sequence
    initial begin
        foreach (chip_mem[i]) chip_mem[i] = 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_status_latch();
        test_memory_edges();
        test_random_frames(1500);
        wait_for_drain();
        repeat (16) @(posedge i_clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog; covers the memory clearing pass after reset with room to spare
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
sv/sfse_pkg.sv
sv/sfse_out_fifo.sv
sv/spi_fram_slave_engine.sv
sv/sfse_checker.sv
tb/testbench.sv
